FILE: hdl/tdpf_pkg.sv
package tdpf_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int FACTOR_W       = 31;
    localparam int MAX_RESULTS    = 30;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int PC_W           = 4;

    localparam int FIRST_PRIME    = 2;
    localparam int FIRST_ODD      = 3;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_NOP,
        OP_EMIT2,
        OP_INIT_D,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_EMIT_D,
        OP_ADV_D,
        OP_EMIT_N,
        OP_FLUSH,
        OP_EMIT_BAD
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_BAD,
        C_ODD_OR_FULL,
        C_FULL_OR_DSQ_GT_N,
        C_REM_NZ,
        C_FULL,
        C_N_LE2_OR_FULL
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] STEP_TWO_TEST  = 4'd2;
    localparam logic [PC_W-1:0] STEP_TWO_EMIT  = 4'd3;
    localparam logic [PC_W-1:0] STEP_INIT_D    = 4'd4;
    localparam logic [PC_W-1:0] STEP_D_TEST    = 4'd5;
    localparam logic [PC_W-1:0] STEP_DIV_START = 4'd6;
    localparam logic [PC_W-1:0] STEP_DIV_WAIT  = 4'd7;
    localparam logic [PC_W-1:0] STEP_EMIT_D    = 4'd8;
    localparam logic [PC_W-1:0] STEP_FULL_TEST = 4'd9;
    localparam logic [PC_W-1:0] STEP_RETRY     = 4'd10;
    localparam logic [PC_W-1:0] STEP_ADV_D     = 4'd11;
    localparam logic [PC_W-1:0] STEP_TAIL      = 4'd12;
    localparam logic [PC_W-1:0] STEP_EMIT_N    = 4'd13;
    localparam logic [PC_W-1:0] STEP_FLUSH     = 4'd14;
    localparam logic [PC_W-1:0] STEP_BAD       = 4'd15;

    function automatic ctrl_word_t cw(op_t op, cond_t cond, logic [PC_W-1:0] target);
        ctrl_word_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            STEP_IDLE:      w = cw(OP_ACCEPT,    C_NO_INPUT,         STEP_IDLE);
            STEP_CHECK:     w = cw(OP_NOP,       C_BAD,              STEP_BAD);
            STEP_TWO_TEST:  w = cw(OP_NOP,       C_ODD_OR_FULL,      STEP_INIT_D);
            STEP_TWO_EMIT:  w = cw(OP_EMIT2,     C_ALWAYS,           STEP_TWO_TEST);
            STEP_INIT_D:    w = cw(OP_INIT_D,    C_NEVER,            STEP_IDLE);
            STEP_D_TEST:    w = cw(OP_NOP,       C_FULL_OR_DSQ_GT_N, STEP_TAIL);
            STEP_DIV_START: w = cw(OP_DIV_START, C_NEVER,            STEP_IDLE);
            STEP_DIV_WAIT:  w = cw(OP_DIV_WAIT,  C_REM_NZ,           STEP_ADV_D);
            STEP_EMIT_D:    w = cw(OP_EMIT_D,    C_NEVER,            STEP_IDLE);
            STEP_FULL_TEST: w = cw(OP_NOP,       C_FULL,             STEP_TAIL);
            STEP_RETRY:     w = cw(OP_NOP,       C_ALWAYS,           STEP_DIV_START);
            STEP_ADV_D:     w = cw(OP_ADV_D,     C_ALWAYS,           STEP_D_TEST);
            STEP_TAIL:      w = cw(OP_NOP,       C_N_LE2_OR_FULL,    STEP_FLUSH);
            STEP_EMIT_N:    w = cw(OP_EMIT_N,    C_NEVER,            STEP_IDLE);
            STEP_FLUSH:     w = cw(OP_FLUSH,     C_ALWAYS,           STEP_IDLE);
            STEP_BAD:       w = cw(OP_EMIT_BAD,  C_ALWAYS,           STEP_IDLE);
            default:        w = cw(OP_NOP,       C_ALWAYS,           STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/tdpf_in_if.sv
interface tdpf_in_if #(
    parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

FILE: hdl/tdpf_out_if.sv
interface tdpf_out_if;
    import tdpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] factor;
    logic                is_last;
    logic                not_possible;

    modport source (output valid, output factor, output is_last, output not_possible,
                    input ready);
    modport sink   (input valid, input factor, input is_last, input not_possible,
                    output ready);
endinterface

FILE: hdl/trial_division_prime_factorizer_unit.sv
// Trial-division prime factorizer.
// number (sink): one signed integer per item. result (source): its prime
// factors in ascending order, repeats included, one item per factor; the
// final item of a run has is_last set. An input of 1 or less gives a single
// item with factor 0, is_last 1 and not_possible 1.
// A microcode table steps a small datapath: factors of 2 are shifted out,
// then odd trial divisors are tried through one restoring divider that
// yields quotient and remainder. Worst case at 32 bits is about 23170
// divisors.
// One item is in work at a time; number.ready is high only between runs.
// Each factor waits in a one-entry holding register until the next one is
// known, so is_last can be set; a stalled receiver holds the sequencer at
// the next emit step while the output register keeps its item.
// Reset returns the sequencer to its idle step and empties the output.
module trial_division_prime_factorizer_unit #(
    parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    tdpf_in_if.sink           number,
    tdpf_out_if.source        result
);
    import tdpf_pkg::*;

    localparam int DW     = (VALUE_BITS + 1) / 2 + 1;
    localparam int DSQ_W  = VALUE_BITS + 1;
    localparam int DCNT_W = $clog2(VALUE_BITS + 1);

    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [DSQ_W-1:0]      dsq_reg, dsq_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FACTOR_W-1:0]   pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic [FACTOR_W-1:0]   out_factor_reg, out_factor_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_np_reg, out_np_next;

    logic                  div_busy_reg, div_busy_next;
    logic [VALUE_BITS-1:0] div_q_reg, div_q_next;
    logic [DW-1:0]         div_r_reg, div_r_next;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [DW:0]           div_shift;
    logic                  div_ge;

    ctrl_word_t            ctrl;
    logic                  cond_true;
    logic                  stall;
    logic                  out_free;
    logic                  full;
    logic                  emit_op;
    logic [FACTOR_W-1:0]   emit_val;

    assign ctrl     = ucode(pc_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign full     = (count_reg == CNT_W'(MAX_RESULTS));
    assign emit_op  = (ctrl.op == OP_EMIT2) || (ctrl.op == OP_EMIT_D) || (ctrl.op == OP_EMIT_N);

    assign number.ready        = (ctrl.op == OP_ACCEPT);
    assign result.valid        = out_valid_reg;
    assign result.factor       = out_factor_reg;
    assign result.is_last      = out_last_reg;
    assign result.not_possible = out_np_reg;

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:            cond_true = 1'b0;
            C_ALWAYS:           cond_true = 1'b1;
            C_NO_INPUT:         cond_true = !number.valid;
            C_BAD:              cond_true = n_reg[VALUE_BITS-1] || (n_reg <= VALUE_BITS'(1));
            C_ODD_OR_FULL:      cond_true = n_reg[0] || full;
            C_FULL_OR_DSQ_GT_N: cond_true = full || (dsq_reg > DSQ_W'(n_reg));
            C_REM_NZ:           cond_true = (div_r_reg != '0);
            C_FULL:             cond_true = full;
            C_N_LE2_OR_FULL:    cond_true = full || (n_reg <= VALUE_BITS'(FIRST_PRIME));
            default:            cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.op)
            OP_DIV_WAIT:  stall = div_busy_reg;
            OP_EMIT2:     stall = pend_valid_reg && !out_free;
            OP_EMIT_D:    stall = pend_valid_reg && !out_free;
            OP_EMIT_N:    stall = pend_valid_reg && !out_free;
            OP_FLUSH:     stall = !out_free;
            OP_EMIT_BAD:  stall = !out_free;
            default:      stall = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.op)
            OP_EMIT2:  emit_val = FACTOR_W'(FIRST_PRIME);
            OP_EMIT_D: emit_val = FACTOR_W'(d_reg);
            default:   emit_val = FACTOR_W'(n_reg);
        endcase
    end

    assign div_shift = {div_r_reg, div_q_reg[VALUE_BITS-1]};
    assign div_ge    = (div_shift >= {1'b0, d_reg});

    always_comb
    begin
        pc_next         = pc_reg;
        n_next          = n_reg;
        d_next          = d_reg;
        dsq_next        = dsq_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_factor_next = out_factor_reg;
        out_last_next   = out_last_reg;
        out_np_next     = out_np_reg;
        div_busy_next   = div_busy_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_cnt_next    = div_cnt_reg;

        if (!stall)
        begin
            pc_next = cond_true ? ctrl.target : pc_reg + PC_W'(1);
        end

        if (div_busy_reg)
        begin
            div_q_next    = {div_q_reg[VALUE_BITS-2:0], div_ge};
            div_r_next    = div_ge ? DW'(div_shift - {1'b0, d_reg}) : div_shift[DW-1:0];
            div_cnt_next  = div_cnt_reg - DCNT_W'(1);
            div_busy_next = (div_cnt_reg != DCNT_W'(1));
        end

        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (number.valid)
                begin
                    n_next          = VALUE_BITS'(unsigned'(number.value));
                    count_next      = '0;
                    pend_valid_next = 1'b0;
                end
            end
            OP_INIT_D:
            begin
                d_next   = DW'(FIRST_ODD);
                dsq_next = DSQ_W'(FIRST_ODD * FIRST_ODD);
            end
            OP_DIV_START:
            begin
                div_q_next    = n_reg;
                div_r_next    = '0;
                div_cnt_next  = DCNT_W'(VALUE_BITS);
                div_busy_next = 1'b1;
            end
            OP_ADV_D:
            begin
                d_next   = d_reg + DW'(2);
                dsq_next = dsq_reg + DSQ_W'({d_reg, 2'b00}) + DSQ_W'(4);
            end
            OP_FLUSH:
            begin
                if (!stall)
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = pend_reg;
                    out_last_next   = 1'b1;
                    out_np_next     = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            OP_EMIT_BAD:
            begin
                if (!stall)
                begin
                    out_valid_next  = 1'b1;
                    out_factor_next = '0;
                    out_last_next   = 1'b1;
                    out_np_next     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (emit_op && !stall)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_factor_next = pend_reg;
                out_last_next   = 1'b0;
                out_np_next     = 1'b0;
            end
            pend_next       = emit_val;
            pend_valid_next = 1'b1;
            count_next      = count_reg + CNT_W'(1);
            if (ctrl.op == OP_EMIT2)
            begin
                n_next = n_reg >> 1;
            end
            else if (ctrl.op == OP_EMIT_D)
            begin
                n_next = div_q_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= STEP_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_busy_reg   <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            div_busy_reg   <= div_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        d_reg          <= d_next;
        dsq_reg        <= dsq_next;
        pend_reg       <= pend_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
        out_np_reg     <= out_np_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        div_cnt_reg    <= div_cnt_next;
    end

`ifndef SYNTHESIS
    a_np_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.not_possible |-> result.is_last && (result.factor == '0))
        else $error("not_possible item is not a lone final item");

    a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> (pc_reg == STEP_DIV_WAIT))
        else $error("divider busy outside its wait step");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count past limit");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        number.valid && number.ready |=> !pend_valid_reg && (count_reg == '0))
        else $error("item accepted with a run still open");
`endif

endmodule

FILE: verif/trial_division_prime_factorizer_unit_tb.sv
`timescale 1ns / 1ps

module trial_division_prime_factorizer_unit_tb;
    import tdpf_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 5_000_000;
    localparam longint unsigned POS_MAX = 64'd2147483647;
    localparam int NUM_SMALL_PRIMES = 25;
    localparam int SMALL_PRIMES [NUM_SMALL_PRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
        53, 59, 61, 67, 71, 73, 79, 83, 89, 97
    };

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic                is_last;
        logic                not_possible;
    } factor_item_t;

    typedef struct {
        logic signed [VB-1:0] value;
        bit                   typed;
        factor_item_t         want;
    } stim_row_t;

    localparam int NUM_ROWS = 21;

    stim_row_t stim_table [NUM_ROWS] = '{
        '{32'sd0,          1'b1, '{31'd0, 1'b1, 1'b1}},
        '{32'sd1,          1'b1, '{31'd0, 1'b1, 1'b1}},
        '{32'shFFFFFFFF,   1'b1, '{31'd0, 1'b1, 1'b1}},
        '{32'sh80000000,   1'b1, '{31'd0, 1'b1, 1'b1}},
        '{32'sd2,          1'b1, '{31'd2, 1'b1, 1'b0}},
        '{32'sd3,          1'b1, '{31'd3, 1'b1, 1'b0}},
        '{32'sd4,          1'b0, '0},
        '{32'sd6,          1'b0, '0},
        '{32'sd8,          1'b0, '0},
        '{32'sd9,          1'b0, '0},
        '{32'sd15,         1'b0, '0},
        '{32'sd25,         1'b0, '0},
        '{32'sd1001,       1'b0, '0},
        '{32'sd9409,       1'b0, '0},
        '{32'sd30030,      1'b0, '0},
        '{32'sd65535,      1'b0, '0},
        '{32'sd2000006,    1'b0, '0},
        '{32'sd1073741824, 1'b0, '0},
        '{32'sd1162261467, 1'b0, '0},
        '{32'sd2147395600, 1'b0, '0},
        '{32'sd2147483647, 1'b1, '{31'h7FFFFFFF, 1'b1, 1'b0}}
    };

    logic clk;
    logic rst_n;

    tdpf_in_if #(.VALUE_BITS(VB)) number_ch ();
    tdpf_out_if result_ch ();

    trial_division_prime_factorizer_unit #(
        .VALUE_BITS(VB)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .result (result_ch)
    );

    factor_item_t pending_factors [$];
    int           error_count = 0;
    longint       cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic factor_item_t prime_item(input longint unsigned f);
        factor_item_t item;
        item.factor       = f[FACTOR_W-1:0];
        item.is_last      = 1'b0;
        item.not_possible = 1'b0;
        return item;
    endfunction

    function automatic void queue_item(input factor_item_t item);
        pending_factors = {pending_factors, item};
    endfunction

    function automatic void factor_number(input logic signed [VB-1:0] v);
        factor_item_t     run [$];
        longint unsigned  n;
        longint unsigned  d;
        if (v <= 1)
        begin
            queue_item(factor_item_t'{factor: '0, is_last: 1'b1, not_possible: 1'b1});
            return;
        end
        n = longint'(v);
        while (n[0] == 1'b0 && run.size() < MAX_RESULTS)
        begin
            run = {run, prime_item(FIRST_PRIME)};
            n = n >> 1;
        end
        d = FIRST_ODD;
        while (run.size() < MAX_RESULTS && d <= n / d)
        begin
            while (n % d == 0 && run.size() < MAX_RESULTS)
            begin
                run = {run, prime_item(d)};
                n = n / d;
            end
            d = d + 2;
        end
        if (n > FIRST_PRIME && run.size() < MAX_RESULTS)
            run = {run, prime_item(n)};
        run[run.size() - 1].is_last = 1'b1;
        foreach (run[i])
            queue_item(run[i]);
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint unsigned smooth_number(input longint unsigned ceiling);
        longint unsigned v;
        longint unsigned p;
        int              steps;
        v = 1;
        steps = $urandom_range(1, 40);
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                p = SMALL_PRIMES[$urandom_range(0, 3)];
            else
                p = SMALL_PRIMES[$urandom_range(0, NUM_SMALL_PRIMES - 1)];
            if (v * p > ceiling)
                break;
            v = v * p;
        end
        return v;
    endfunction

    function automatic logic signed [VB-1:0] random_number();
        int unsigned     pick;
        longint unsigned v;
        longint unsigned m;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return $urandom | 32'h8000_0000;
        if (pick < 15)
            return $urandom_range(0, 1);
        if (pick < 40)
            return $urandom_range(2, 20000);
        if (pick < 88)
        begin
            v = smooth_number(POS_MAX);
            if (v < FIRST_PRIME)
                v = FIRST_PRIME;
        end
        else
        begin
            m = $urandom_range(2, 200000);
            v = m * smooth_number(POS_MAX / m);
        end
        return v[VB-1:0];
    endfunction

    task automatic send_number(input logic signed [VB-1:0] v, input bit typed,
                               input factor_item_t want, input int gap);
        if (gap > 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= v;
        @(posedge clk);
        while (number_ch.ready !== 1'b1)
            @(posedge clk);
        if (typed)
            queue_item(want);
        else
            factor_number(v);
        @(negedge clk);
    endtask

    task automatic wait_for_quiet();
        number_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_factors.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("trial_division_prime_factorizer_unit_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        factor_item_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_factors.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected item: factor %0d last %0b np %0b",
                             result_ch.factor, result_ch.is_last, result_ch.not_possible);
            end
            else
            begin
                want = pending_factors.pop_front();
                if (result_ch.factor !== want.factor || result_ch.is_last !== want.is_last
                    || result_ch.not_possible !== want.not_possible)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: want factor %0d last %0b np %0b, got %0d %0b %0b",
                                 want.factor, want.is_last, want.not_possible,
                                 result_ch.factor, result_ch.is_last,
                                 result_ch.not_possible);
                end
            end
        end
    end

    initial
    begin : drive_result_ready
        int gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(50, 300)) @(negedge clk);
            else
            begin
                repeat ($urandom_range(1, 8)) @(negedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_number(stim_table[i].value, stim_table[i].typed, stim_table[i].want,
                        (i < 6) ? 0 : pick_gap());

        wait_for_quiet();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 24)
                wait_for_quiet();
            send_number(random_number(), 1'b0, '0, (i % 16 < 5) ? 0 : pick_gap());
        end
        number_ch.valid <= 1'b0;

        while (pending_factors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("trial_division_prime_factorizer_unit_tb: done, clean");
        else
            $display("trial_division_prime_factorizer_unit_tb: done, errors");
        $finish;
    end

endmodule
